// ----- sv/qrm_pkg.sv -----
// Shared constants and pipeline types for the quaternion to rotation matrix block.
`default_nettype none
package qrm_pkg;
  localparam int FRAC_BITS = 14;
  localparam int QW = FRAC_BITS + 1;   // quotient bits, quotient never exceeds 2^FRAC_BITS
  localparam int RW = 33;              // sum of squares and remainder width
  localparam int NW = 34;              // signed numerator width
  localparam int DW = RW + FRAC_BITS + 1;
  localparam int NUM_EL = 9;
  localparam int PW = 32;              // 16x16 product width

  // one matrix element in flight through the divider chain
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic          neg;
  } lane_t;

  // one beat in flight through the divider chain
  typedef struct packed {
    logic                       valid;
    logic                       zero;
    logic [RW-1:0]              s;
    lane_t [NUM_EL-1:0]         lane;
  } stage_t;
endpackage
`default_nettype wire

// ----- sv/qrm_if.sv -----
// Valid/ready channel interfaces for quaternion beats and matrix beats.
`default_nettype none
interface qrm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic               zero_norm;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                output ready);
endinterface
`default_nettype wire

// ----- sv/quaternion_to_rotation_matrix_top.sv -----
// Quaternion to rotation matrix: usage
//   in_ch  carries one quaternion beat (q_w, q_x, q_y, q_z, signed Q1.14).
//   out_ch carries one matrix beat (m00..m22, signed Q1.14, and zero_norm).
//   Every accepted quaternion gives exactly one matrix beat, in order.
//   The stages are the input register, product stage, numerator stage,
//   dividend stage, 15 divider cells (one quotient bit each, FRAC_BITS+1)
//   and the output register.
//   Throughput is one beat per cycle unless out_ch stalls; the divider
//   chain is fully pipelined and a new quaternion enters each cycle.
//   Elements are exact rational quotients rounded to nearest, ties away
//   from zero. A zero quaternion gives a zero matrix and zero_norm high.
//   Reset (rst_n low, synchronous) empties the pipeline; out_ch.valid drops.
//   When the receiver stalls with the output register full, the whole
//   pipeline holds and in_ch.ready drops in the same cycle; while the output
//   register is empty, beats keep flowing regardless of out_ch.ready.
`default_nettype none
module quaternion_to_rotation_matrix_top (
  input wire logic  clk,
  input wire logic  rst_n,
  qrm_in_if.sink    in_ch,
  qrm_out_if.source out_ch
);
  logic en;
  logic out_valid_r;
  logic signed [15:0] m_r [qrm_pkg::NUM_EL];
  logic zero_r;
  qrm_pkg::stage_t chain [qrm_pkg::QW+1];
  logic signed [15:0] m_nxt [qrm_pkg::NUM_EL];

  // advance whenever the output register can take a beat
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  qrm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_w     (in_ch.q_w),
    .in_x     (in_ch.q_x),
    .in_y     (in_ch.q_y),
    .in_z     (in_ch.q_z),
    .stage_o  (chain[0])
  );

  for (genvar g = 0; g < qrm_pkg::QW; g++) begin : g_cell
    qrm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // clamp, apply sign and fit each element to the output width
  always_comb begin
    logic [qrm_pkg::QW-1:0] q;
    logic signed [qrm_pkg::QW:0] v;
    for (int i = 0; i < qrm_pkg::NUM_EL; i++) begin
      q = chain[qrm_pkg::QW].lane[i].quo;
      if (q > (qrm_pkg::QW'(1) << qrm_pkg::FRAC_BITS)) begin
        q = qrm_pkg::QW'(1) << qrm_pkg::FRAC_BITS;
      end
      v = signed'({1'b0, q});
      if (chain[qrm_pkg::QW].lane[i].neg) begin
        v = -v;
      end
      if (chain[qrm_pkg::QW].zero) begin
        v = '0;
      end
      m_nxt[i] = 16'(v);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[qrm_pkg::QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      zero_r <= chain[qrm_pkg::QW].zero;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.m00 = m_r[0];
  assign out_ch.m01 = m_r[1];
  assign out_ch.m02 = m_r[2];
  assign out_ch.m10 = m_r[3];
  assign out_ch.m11 = m_r[4];
  assign out_ch.m12 = m_r[5];
  assign out_ch.m20 = m_r[6];
  assign out_ch.m21 = m_r[7];
  assign out_ch.m22 = m_r[8];
  assign out_ch.zero_norm = zero_r;

  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> m_r[0] == 16'sd0 && m_r[4] == 16'sd0 && m_r[8] == 16'sd0)
    else $error("zero norm beat with nonzero diagonal");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> m_r[0] <= 16'sd16384 && m_r[0] >= -16'sd16384)
    else $error("element outside plus or minus one");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled and full");
endmodule
`default_nettype wire

// ----- sv/qrm_front.sv -----
// Front end: products, numerators, sum of squares and divider setup.
`default_nettype none
module qrm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] in_w,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_z,
  output qrm_pkg::stage_t         stage_o
);
  logic v1_r, v2_r, v3_r;
  logic signed [15:0] w_r, x_r, y_r, z_r;
  logic signed [qrm_pkg::PW-1:0] p_r [10];
  logic signed [qrm_pkg::NW-1:0] n_r [qrm_pkg::NUM_EL];
  logic [qrm_pkg::RW-1:0] s_r;
  qrm_pkg::stage_t st_nxt, st_r;

  // valid bits and the stage handed to the first divider cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      st_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      st_r.valid <= v3_r;
    end
    if (en) begin
      st_r.zero <= st_nxt.zero;
      st_r.s <= st_nxt.s;
      st_r.lane <= st_nxt.lane;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= in_w;
      x_r <= in_x;
      y_r <= in_y;
      z_r <= in_z;
      p_r[0] <= w_r * w_r;
      p_r[1] <= x_r * x_r;
      p_r[2] <= y_r * y_r;
      p_r[3] <= z_r * z_r;
      p_r[4] <= x_r * y_r;
      p_r[5] <= w_r * z_r;
      p_r[6] <= x_r * z_r;
      p_r[7] <= w_r * y_r;
      p_r[8] <= y_r * z_r;
      p_r[9] <= w_r * x_r;
      s_r <= qrm_pkg::RW'(p_r[0]) + qrm_pkg::RW'(p_r[1])
           + qrm_pkg::RW'(p_r[2]) + qrm_pkg::RW'(p_r[3]);
      n_r[0] <= qrm_pkg::NW'(p_r[0]) + qrm_pkg::NW'(p_r[1])
              - qrm_pkg::NW'(p_r[2]) - qrm_pkg::NW'(p_r[3]);
      n_r[1] <= (qrm_pkg::NW'(p_r[4]) - qrm_pkg::NW'(p_r[5])) <<< 1;
      n_r[2] <= (qrm_pkg::NW'(p_r[6]) + qrm_pkg::NW'(p_r[7])) <<< 1;
      n_r[3] <= (qrm_pkg::NW'(p_r[4]) + qrm_pkg::NW'(p_r[5])) <<< 1;
      n_r[4] <= qrm_pkg::NW'(p_r[0]) - qrm_pkg::NW'(p_r[1])
              + qrm_pkg::NW'(p_r[2]) - qrm_pkg::NW'(p_r[3]);
      n_r[5] <= (qrm_pkg::NW'(p_r[8]) - qrm_pkg::NW'(p_r[9])) <<< 1;
      n_r[6] <= (qrm_pkg::NW'(p_r[6]) - qrm_pkg::NW'(p_r[7])) <<< 1;
      n_r[7] <= (qrm_pkg::NW'(p_r[8]) + qrm_pkg::NW'(p_r[9])) <<< 1;
      n_r[8] <= qrm_pkg::NW'(p_r[0]) - qrm_pkg::NW'(p_r[1])
              - qrm_pkg::NW'(p_r[2]) + qrm_pkg::NW'(p_r[3]);
    end
  end

  // form rounded dividend and split it into starting remainder and low bits
  always_comb begin
    logic [qrm_pkg::NW-1:0] mag;
    logic [qrm_pkg::DW-1:0] dvd;
    st_nxt = st_r;
    st_nxt.valid = v3_r;
    st_nxt.zero = (s_r == '0);
    st_nxt.s = s_r;
    for (int i = 0; i < qrm_pkg::NUM_EL; i++) begin
      mag = n_r[i][qrm_pkg::NW-1] ? qrm_pkg::NW'(-n_r[i]) : qrm_pkg::NW'(n_r[i]);
      dvd = {mag[qrm_pkg::RW-1:0], {qrm_pkg::FRAC_BITS{1'b0}}, 1'b0} >> 1;
      dvd = dvd + qrm_pkg::DW'(s_r >> 1);
      st_nxt.lane[i].rem = dvd[qrm_pkg::DW-1:qrm_pkg::QW];
      st_nxt.lane[i].low = dvd[qrm_pkg::QW-1:0];
      st_nxt.lane[i].quo = '0;
      st_nxt.lane[i].neg = n_r[i][qrm_pkg::NW-1];
    end
  end

  assign stage_o = st_r;
endmodule
`default_nettype wire

// ----- sv/qrm_div_cell.sv -----
// One restoring division cell: one quotient bit for all nine elements.
`default_nettype none
module qrm_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire qrm_pkg::stage_t stage_i,
  output qrm_pkg::stage_t      stage_o
);
  qrm_pkg::stage_t st_nxt, st_r;

  // shift in the next dividend bit and subtract the divisor where it fits
  always_comb begin
    logic [qrm_pkg::RW:0] t;
    logic ge;
    st_nxt = stage_i;
    for (int i = 0; i < qrm_pkg::NUM_EL; i++) begin
      t = {stage_i.lane[i].rem, stage_i.lane[i].low[qrm_pkg::QW-1]};
      ge = (t >= {1'b0, stage_i.s});
      st_nxt.lane[i].rem = ge ? qrm_pkg::RW'(t - {1'b0, stage_i.s}) : t[qrm_pkg::RW-1:0];
      st_nxt.lane[i].low = {stage_i.lane[i].low[qrm_pkg::QW-2:0], 1'b0};
      st_nxt.lane[i].quo = {stage_i.lane[i].quo[qrm_pkg::QW-2:0], ge};
    end
  end

  // advance to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_nxt.valid;
    end
    if (en) begin
      st_r.zero <= st_nxt.zero;
      st_r.s <= st_nxt.s;
      st_r.lane <= st_nxt.lane;
    end
  end

  assign stage_o = st_r;
endmodule
`default_nettype wire
